>>> hw/rtl/cpc_pkg.sv
// Shared types and constants for the pressure/temperature compensation pipeline.
// No dependencies; every other file in hw/rtl imports this package.
package cpc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SENS_BASE     = 3'd0,
    REG_OFFSET_BASE   = 3'd1,
    REG_SENS_TEMPCO   = 3'd2,
    REG_OFFSET_TEMPCO = 3'd3,
    REG_REF_TEMP      = 3'd4,
    REG_TEMP_SLOPE    = 3'd5,
    REG_BAND_LOW      = 3'd6,
    REG_BAND_HIGH     = 3'd7
  } reg_idx_t;

  localparam logic [17:0] BAND_LOW_RST  = 18'd1000;
  localparam logic [17:0] BAND_HIGH_RST = 18'd120000;

  // 20.00 C in hundredths, and the offset that moves the -15.00 C knee to zero
  localparam logic signed [19:0] TEMP_BASE = 20'sd2000;
  localparam logic signed [18:0] VLOW_OFS  = 19'sd3500;

  // Output saturation limits (19-bit signed)
  localparam logic signed [31:0] OUT_MAX = 32'sd262143;
  localparam logic signed [31:0] OUT_MIN = -32'sd262144;

  // Register stages from input transfer to output register
  localparam int unsigned CPC_DEPTH = 9;

  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
    logic [17:0] band_low;
    logic [17:0] band_high;
  } cfg_t;

  // First-order terms
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [17:0] tm;    // TEMP - 2000
    logic        [16:0] t2;
    logic signed [35:0] off;
    logic signed [33:0] sens;
  } base_t;

  // Fully compensated terms
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [19:0] temp;
    logic signed [40:0] off;
    logic signed [40:0] sens;
  } comp_t;

endpackage

>>> hw/rtl/cpc_front.sv
// First-order compensation: dT, the four products on dT, and TEMP/OFF/SENS.
// Three register stages. Depends on cpc_pkg.
module cpc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  cpc_pkg::cfg_t  cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  logic [23:0]    pressure_code,
  input  logic [23:0]    temperature_code,
  output logic           dn_valid,
  input  logic           dn_ready,
  output cpc_pkg::base_t dn_data
);
  import cpc_pkg::*;

  logic               v1_r, v2_r, v3_r;
  logic               rdy1, rdy2, rdy3;
  logic        [23:0] d1a_r, d1b_r;
  logic signed [24:0] dt_nxt, dt_r;
  logic signed [16:0] c6s, c4s, c3s;
  logic signed [40:0] mt_nxt, mo_nxt, ms_nxt;
  logic signed [40:0] mt_r, mo_r, ms_r;
  logic signed [49:0] mdd_full;
  logic        [47:0] mdd_r;
  base_t              base_nxt, base_r;

  // Stall chain: a stage takes new data when empty or when it drains
  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  // Stage 1: temperature difference
  assign dt_nxt = $signed({1'b0, temperature_code}) - $signed({1'b0, cfg.c5, 8'h00});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      dt_r  <= dt_nxt;
      d1a_r <= pressure_code;
    end
  end

  // Stage 2: products on dT
  assign c6s      = $signed({1'b0, cfg.c6});
  assign c4s      = $signed({1'b0, cfg.c4});
  assign c3s      = $signed({1'b0, cfg.c3});
  assign mt_nxt   = dt_r * c6s;
  assign mo_nxt   = dt_r * c4s;
  assign ms_nxt   = dt_r * c3s;
  assign mdd_full = dt_r * dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      mt_r  <= mt_nxt;
      mo_r  <= mo_nxt;
      ms_r  <= ms_nxt;
      mdd_r <= mdd_full[47:0];
      d1b_r <= d1a_r;
    end
  end

  // Stage 3: floor shifts and base terms
  always_comb begin
    base_nxt.d1   = d1b_r;
    base_nxt.tm   = mt_r[40:23];
    base_nxt.t2   = mdd_r[47:31];
    base_nxt.off  = $signed({4'b0000, cfg.c2, 16'h0000})
                  + $signed({{2{mo_r[40]}}, mo_r[40:7]});
    base_nxt.sens = $signed({3'b000, cfg.c1, 15'h0000})
                  + $signed({ms_r[40], ms_r[40:8]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      base_r <= base_nxt;
    end
  end

  assign dn_valid = v3_r;
  assign dn_data  = base_r;

endmodule

>>> hw/rtl/cpc_second.sv
// Second-order correction below 20.00 C, with the extra term below -15.00 C.
// Three register stages. Depends on cpc_pkg.
module cpc_second (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  cpc_pkg::base_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output cpc_pkg::comp_t dn_data
);
  import cpc_pkg::*;

  logic               v1_r, v2_r, v3_r;
  logic               rdy1, rdy2, rdy3;
  logic signed [35:0] sqa;
  logic signed [18:0] tp;
  logic signed [37:0] sqb;
  logic        [33:0] sq1_r, sq2_r;
  logic               lo_r, vlo_r;
  logic signed [19:0] temp_nxt, tempa_r, tempb_r;
  logic        [16:0] t2_r;
  logic signed [35:0] offa_r, offb_r;
  logic signed [33:0] sensa_r, sensb_r;
  logic        [23:0] d1a_r, d1b_r;
  logic        [37:0] f5, f7, f11;
  logic        [38:0] off2_nxt, sens2_nxt, off2_r, sens2_r;
  logic signed [19:0] tempf_nxt;
  comp_t              comp_nxt, comp_r;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  // Stage 1: squares of (TEMP-2000) and (TEMP+1500)
  assign sqa      = up_data.tm * up_data.tm;
  assign tp       = $signed({up_data.tm[17], up_data.tm}) + VLOW_OFS;
  assign sqb      = tp * tp;
  assign temp_nxt = $signed({{2{up_data.tm[17]}}, up_data.tm}) + TEMP_BASE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      sq1_r   <= sqa[33:0];
      sq2_r   <= sqb[33:0];
      lo_r    <= up_data.tm[17];
      vlo_r   <= tp[18];
      tempa_r <= temp_nxt;
      t2_r    <= up_data.t2;
      offa_r  <= up_data.off;
      sensa_r <= up_data.sens;
      d1a_r   <= up_data.d1;
    end
  end

  // Stage 2: OFF2, SENS2 by shift-add, corrected TEMP
  assign f5  = {2'b00, sq1_r, 2'b00} + {4'b0000, sq1_r};
  assign f7  = {1'b0, sq2_r, 3'b000} - {4'b0000, sq2_r};
  assign f11 = {1'b0, sq2_r, 3'b000} + {3'b000, sq2_r, 1'b0} + {4'b0000, sq2_r};

  always_comb begin
    off2_nxt  = '0;
    sens2_nxt = '0;
    tempf_nxt = tempa_r;
    if (lo_r) begin
      off2_nxt  = {2'b00, f5[37:1]};
      sens2_nxt = {3'b000, f5[37:2]};
      if (vlo_r) begin
        off2_nxt  = off2_nxt + {1'b0, f7};
        sens2_nxt = sens2_nxt + {2'b00, f11[37:1]};
      end
      tempf_nxt = tempa_r - $signed({3'b000, t2_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      off2_r  <= off2_nxt;
      sens2_r <= sens2_nxt;
      tempb_r <= tempf_nxt;
      offb_r  <= offa_r;
      sensb_r <= sensa_r;
      d1b_r   <= d1a_r;
    end
  end

  // Stage 3: apply corrections to OFF and SENS
  always_comb begin
    comp_nxt.d1   = d1b_r;
    comp_nxt.temp = tempb_r;
    comp_nxt.off  = $signed({{5{offb_r[35]}}, offb_r}) - $signed({2'b00, off2_r});
    comp_nxt.sens = $signed({{7{sensb_r[33]}}, sensb_r}) - $signed({2'b00, sens2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      comp_r <= comp_nxt;
    end
  end

  assign dn_valid = v3_r;
  assign dn_data  = comp_r;

endmodule

>>> hw/rtl/cpc_press.sv
// Pressure: split D1*SENS product, floor shifts, saturation and band test.
// Three register stages, the last one is the output register. Depends on cpc_pkg.
module cpc_press (
  input  logic               clk,
  input  logic               rst_n,
  input  cpc_pkg::cfg_t      cfg,
  input  logic               up_valid,
  output logic               up_ready,
  input  cpc_pkg::comp_t     up_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [18:0] temperature_centi,
  output logic signed [18:0] pressure_pascal,
  output logic               in_band
);
  import cpc_pkg::*;

  logic               v1_r, v2_r, v3_r;
  logic               rdy1, rdy2, rdy3;
  logic        [44:0] pl_nxt, pl_r;
  logic signed [44:0] ph_nxt, ph_r;
  logic signed [40:0] offa_r;
  logic signed [19:0] tempa_r, tempb_r;
  logic signed [46:0] diff_nxt, diff_r;
  logic signed [31:0] p;
  logic signed [18:0] press_nxt, temp_nxt, press_r, temp_r;
  logic               band_nxt, band_r;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  // Stage 1: two partial products, SENS split at bit 21
  assign pl_nxt = {21'd0, up_data.d1} * {24'd0, up_data.sens[20:0]};
  assign ph_nxt = $signed({1'b0, up_data.d1}) * $signed(up_data.sens[40:21]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      pl_r    <= pl_nxt;
      ph_r    <= ph_nxt;
      offa_r  <= up_data.off;
      tempa_r <= up_data.temp;
    end
  end

  // Stage 2: floor(D1*SENS / 2^21) - OFF
  assign diff_nxt = $signed({{2{ph_r[44]}}, ph_r}) + $signed({23'd0, pl_r[44:21]})
                  - $signed({{6{offa_r[40]}}, offa_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      diff_r  <= diff_nxt;
      tempb_r <= tempa_r;
    end
  end

  // Stage 3: final shift, saturate, band test on the unsaturated pressure
  assign p = diff_r[46:15];

  always_comb begin
    priority if (p > OUT_MAX) begin
      press_nxt = OUT_MAX[18:0];
    end else if (p < OUT_MIN) begin
      press_nxt = OUT_MIN[18:0];
    end else begin
      press_nxt = p[18:0];
    end
    priority if ($signed({{12{tempb_r[19]}}, tempb_r}) > OUT_MAX) begin
      temp_nxt = OUT_MAX[18:0];
    end else if ($signed({{12{tempb_r[19]}}, tempb_r}) < OUT_MIN) begin
      temp_nxt = OUT_MIN[18:0];
    end else begin
      temp_nxt = tempb_r[18:0];
    end
    band_nxt = (p >= $signed({14'd0, cfg.band_low})) &&
               (p <= $signed({14'd0, cfg.band_high}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      press_r <= press_nxt;
      temp_r  <= temp_nxt;
      band_r  <= band_nxt;
    end
  end

  assign out_valid         = v3_r;
  assign temperature_centi = temp_r;
  assign pressure_pascal   = press_r;
  assign in_band           = band_r;

endmodule

>>> hw/rtl/pressure_temperature_compensation_unit.sv
// Top level: calibration registers and the three pipeline sections.
// Depends on cpc_pkg, cpc_front, cpc_second, cpc_press.
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------------------
//   input     | in_valid / in_ready  | in_pressure_code, in_temperature_code
//   result    | out_valid / out_ready| out_temperature_centi, out_pressure_pascal,
//             |                      | out_in_band
//   config    | cfg_we               | cfg_index, cfg_wdata
//
// Nine register stages; one transfer per cycle while out_ready stays high.
// The depth is set by the chain dT -> products -> base terms -> squares ->
// OFF2/SENS2 -> corrections -> split D1*SENS product -> minus OFF -> final shift.
// Each stage stalls on its own, so bubbles close up while the output waits.
// Synchronous active-low reset empties the pipeline and loads register defaults.
module pressure_temperature_compensation_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [17:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        in_pressure_code,
  input  logic [23:0]        in_temperature_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [18:0] out_temperature_centi,
  output logic signed [18:0] out_pressure_pascal,
  output logic               out_in_band
);
  import cpc_pkg::*;

  cfg_t  cfg_r;
  base_t base_data;
  comp_t comp_data;
  logic  base_valid, base_ready, comp_valid, comp_ready;

  // Calibration and band registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c1        <= '0;
      cfg_r.c2        <= '0;
      cfg_r.c3        <= '0;
      cfg_r.c4        <= '0;
      cfg_r.c5        <= '0;
      cfg_r.c6        <= '0;
      cfg_r.band_low  <= BAND_LOW_RST;
      cfg_r.band_high <= BAND_HIGH_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SENS_BASE:     cfg_r.c1        <= cfg_wdata[15:0];
        REG_OFFSET_BASE:   cfg_r.c2        <= cfg_wdata[15:0];
        REG_SENS_TEMPCO:   cfg_r.c3        <= cfg_wdata[15:0];
        REG_OFFSET_TEMPCO: cfg_r.c4        <= cfg_wdata[15:0];
        REG_REF_TEMP:      cfg_r.c5        <= cfg_wdata[15:0];
        REG_TEMP_SLOPE:    cfg_r.c6        <= cfg_wdata[15:0];
        REG_BAND_LOW:      cfg_r.band_low  <= cfg_wdata;
        REG_BAND_HIGH:     cfg_r.band_high <= cfg_wdata;
      endcase
    end
  end

  cpc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .up_valid         (in_valid),
    .up_ready         (in_ready),
    .pressure_code    (in_pressure_code),
    .temperature_code (in_temperature_code),
    .dn_valid         (base_valid),
    .dn_ready         (base_ready),
    .dn_data          (base_data)
  );

  cpc_second u_second (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (base_valid),
    .up_ready (base_ready),
    .up_data  (base_data),
    .dn_valid (comp_valid),
    .dn_ready (comp_ready),
    .dn_data  (comp_data)
  );

  cpc_press u_press (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .up_valid          (comp_valid),
    .up_ready          (comp_ready),
    .up_data           (comp_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .temperature_centi (out_temperature_centi),
    .pressure_pascal   (out_pressure_pascal),
    .in_band           (out_in_band)
  );

endmodule

>>> hw/rtl/cpc_checker.sv
// Port-level checks for the compensation unit, bound to the top level.
// Depends on cpc_pkg and pressure_temperature_compensation_unit.
module cpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [18:0] out_temperature_centi,
  input logic signed [18:0] out_pressure_pascal,
  input logic               out_in_band
);
  import cpc_pkg::*;

  logic [3:0] pend_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Track items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {3'b000, in_xfer} - {3'b000, out_xfer};
    end
  end

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_temperature_centi)
      && $stable(out_pressure_pascal) && $stable(out_in_band))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without an accepted input");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'(CPC_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_band_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_band |-> !out_pressure_pascal[18])
    else $error("in-band flag on a negative pressure");

endmodule

bind pressure_temperature_compensation_unit cpc_checker u_cpc_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_temperature_centi (out_temperature_centi),
  .out_pressure_pascal   (out_pressure_pascal),
  .out_in_band           (out_in_band)
);

>>> verif/tb_pressure_temperature_compensation_unit.sv
// Self-checking testbench for pressure_temperature_compensation_unit: random and
// directed sensor code pairs, an internal compensation predictor and a result check.
// Depends on cpc_pkg and the unit's RTL.
module tb_pressure_temperature_compensation_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cpc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 250;
  localparam logic [23:0] TYP_D1 = 24'd9085466;
  localparam logic [23:0] TYP_D2 = 24'd8569150;

  typedef struct {
    logic [23:0] d1;
    logic [23:0] d2;
  } sensor_pair_t;

  typedef struct {
    logic signed [18:0] temp_centi;
    logic signed [18:0] press_pa;
    logic               in_band;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [17:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [23:0]        in_pressure_code = '0;
  logic [23:0]        in_temperature_code = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [18:0] out_temperature_centi;
  logic signed [18:0] out_pressure_pascal;
  logic               out_in_band;

  // Calibration copy kept in step with every register write
  longint cal_c [6];
  longint band_lo = 1000;
  longint band_hi = 120000;

  sensor_pair_t stim_q [$];
  reading_t     reading_q [$];
  int           bad_readings = 0;
  int           cycles = 0;
  bit           steady = 1'b0;

  pressure_temperature_compensation_unit DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_pressure_code      (in_pressure_code),
    .in_temperature_code   (in_temperature_code),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_pascal   (out_pressure_pascal),
    .out_in_band           (out_in_band)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [18:0] sat19(input longint v);
    if (v > 262143) return 19'sd262143;
    if (v < -262144) return -19'sd262144;
    return v[18:0];
  endfunction

  // Second-order compensation in 64-bit integers; >>> on signed values floors
  function automatic reading_t compensate_reading(input logic [23:0] d1_code,
                                                  input logic [23:0] d2_code);
    longint   d1, dt, temp, off, sens, sq, t2, off2, sens2, p;
    reading_t r;
    d1 = d1_code;
    dt = d2_code;
    dt = dt - cal_c[4] * 256;
    temp = 2000 + ((dt * cal_c[5]) >>> 23);
    off = cal_c[1] * 65536 + ((cal_c[3] * dt) >>> 7);
    sens = cal_c[0] * 32768 + ((cal_c[2] * dt) >>> 8);
    if (temp < 2000) begin
      t2 = (dt * dt) >>> 31;
      sq = (temp - 2000) * (temp - 2000);
      off2 = (5 * sq) >>> 1;
      sens2 = (5 * sq) >>> 2;
      // very cold: extra term around -15.00 C, from the first-order temperature
      if (temp < -1500) begin
        sq = (temp + 1500) * (temp + 1500);
        off2 += 7 * sq;
        sens2 += (11 * sq) >>> 1;
      end
      temp -= t2;
      off -= off2;
      sens -= sens2;
    end
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    r.temp_centi = sat19(temp);
    r.press_pa = sat19(p);
    // band test on the exact pressure, before saturation
    r.in_band = (p >= band_lo) && (p <= band_hi);
    return r;
  endfunction

  // Driver: present queued pairs, hold until transfer, predict on each transfer
  always @(posedge clk) begin : drive_pairs
    sensor_pair_t pair;
    cycles <= cycles + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        reading_q.push_back(compensate_reading(in_pressure_code, in_temperature_code));
      if (!in_valid || in_ready) begin
        if (stim_q.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
          pair = stim_q.pop_front();
          in_valid <= 1'b1;
          in_pressure_code <= pair.d1;
          in_temperature_code <= pair.d2;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest predicted reading
  always @(posedge clk) begin : check_readings
    reading_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reading_q.size() == 0) begin
          if (bad_readings < 10)
            $display("%0t: unexpected result temp=%0d press=%0d band=%0b", $realtime,
                     out_temperature_centi, out_pressure_pascal, out_in_band);
          bad_readings++;
        end else begin
          want = reading_q.pop_front();
          if (out_temperature_centi !== want.temp_centi ||
              out_pressure_pascal !== want.press_pa || out_in_band !== want.in_band) begin
            if (bad_readings < 10)
              $display("%0t: mismatch temp %0d/%0d press %0d/%0d band %0b/%0b (exp/got)",
                       $realtime, want.temp_centi, out_temperature_centi, want.press_pa,
                       out_pressure_pascal, want.in_band, out_in_band);
            bad_readings++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 28);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("** pressure_temperature_compensation_unit: FAILED **");
      $finish;
    end
  end

  task automatic queue_pair(input logic [23:0] d1, input logic [23:0] d2);
    sensor_pair_t sp;
    sp.d1 = d1;
    sp.d2 = d2;
    stim_q.push_back(sp);
  endtask

  // Hold until nothing is queued, presented or outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (stim_q.size() != 0 || in_valid || reading_q.size() != 0);
  endtask

  // Write one register; the caller closes a batch with close_cfg
  task automatic write_reg(input reg_idx_t idx, input logic [17:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_BAND_LOW:  band_lo = val;
      REG_BAND_HIGH: band_hi = val;
      default:       cal_c[int'(idx)] = val[15:0];
    endcase
  endtask

  task automatic close_cfg();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_typical_cal();
    write_reg(REG_SENS_BASE, 18'd40127);
    write_reg(REG_OFFSET_BASE, 18'd36924);
    write_reg(REG_SENS_TEMPCO, 18'd23317);
    write_reg(REG_OFFSET_TEMPCO, 18'd23282);
    write_reg(REG_REF_TEMP, 18'd33464);
    write_reg(REG_TEMP_SLOPE, 18'd28312);
  endtask

  function automatic logic [17:0] draw_coeff(input int typ);
    case ($urandom_range(0, 5))
      0:       return 18'd0;
      1:       return 18'h3FFFF;
      2, 3:    return 18'($urandom());
      default: return 18'(typ + int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic randomize_cal();
    logic [17:0] a, b;
    write_reg(REG_SENS_BASE, draw_coeff(40127));
    write_reg(REG_OFFSET_BASE, draw_coeff(36924));
    write_reg(REG_SENS_TEMPCO, draw_coeff(23317));
    write_reg(REG_OFFSET_TEMPCO, draw_coeff(23282));
    write_reg(REG_REF_TEMP, draw_coeff(33464));
    write_reg(REG_TEMP_SLOPE, draw_coeff(28312));
    a = 18'($urandom());
    b = 18'($urandom());
    case ($urandom_range(0, 3))
      0: begin a = 18'd0; b = 18'h3FFFF; end
      1: begin a = 18'd1000; b = 18'd120000; end
      2: begin a = (a < b) ? b : a; b = (a == b) ? a - 1 : b; end  // inverted
      default: begin
        a = 18'($urandom_range(0, 100000));
        b = a + 18'($urandom_range(0, 150000));
      end
    endcase
    write_reg(REG_BAND_LOW, a);
    write_reg(REG_BAND_HIGH, b);
  endtask

  // Mostly plausible readings around the reference temperature, the rest raw noise
  task automatic queue_random_pair();
    longint d2;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        d2 = cal_c[4] * 256 + longint'($urandom_range(0, 4000000)) - 2000000;
        if (d2 < 0) d2 = 0;
        if (d2 > 24'hFFFFFF) d2 = 24'hFFFFFF;
        queue_pair(24'($urandom_range(5000000, 12000000)), d2[23:0]);
      end
      5: begin
        d2 = cal_c[4] * 256 + longint'($urandom_range(0, 6)) - 3;
        if (d2 < 0) d2 = 0;
        queue_pair(24'($urandom()), d2[23:0]);
      end
      default: queue_pair(24'($urandom()), 24'($urandom()));
    endcase
  endtask

  initial begin : stimulus
    reading_t ref_typ;
    logic [17:0] typ_pa;
    longint knee;
    logic [23:0] d2;
    cal_c = '{default: 0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset calibration: everything at zero, default band
    queue_pair(24'd0, 24'd0);
    queue_pair(24'hFFFFFF, 24'hFFFFFF);
    queue_pair(24'($urandom()), 24'($urandom()));
    wait_drained();

    // Typical calibration: code extremes, reference point, cold knees
    write_typical_cal();
    close_cfg();
    queue_pair(24'd0, 24'd0);
    queue_pair(24'hFFFFFF, 24'hFFFFFF);
    queue_pair(24'd0, 24'hFFFFFF);
    queue_pair(24'hFFFFFF, 24'd0);
    queue_pair(TYP_D1, TYP_D2);
    // dT of zero keeps first order, one below enters second order
    queue_pair(TYP_D1, 24'(cal_c[4] * 256));
    queue_pair(TYP_D1, 24'(cal_c[4] * 256 - 1));
    // straddle the -15.00 C knee
    knee = (longint'(3500) * 8388608) / cal_c[5];
    for (int k = -1; k <= 1; k++) begin
      d2 = 24'(cal_c[4] * 256 - knee + k);
      queue_pair(TYP_D1, d2);
    end
    wait_drained();

    // Band edges: a band of one pascal around the typical reading
    ref_typ = compensate_reading(TYP_D1, TYP_D2);
    typ_pa = ref_typ.press_pa[17:0];
    write_reg(REG_BAND_LOW, typ_pa);
    write_reg(REG_BAND_HIGH, typ_pa);
    close_cfg();
    queue_pair(TYP_D1, TYP_D2);
    queue_pair(TYP_D1 + 24'd5000, TYP_D2);
    wait_drained();

    // Inverted band never matches
    write_reg(REG_BAND_LOW, typ_pa + 18'd1);
    close_cfg();
    queue_pair(TYP_D1, TYP_D2);
    wait_drained();

    // Full band; saturated pressure must stay out of band
    write_reg(REG_BAND_LOW, 18'd0);
    write_reg(REG_BAND_HIGH, 18'h3FFFF);
    close_cfg();
    queue_pair(24'hFFFFFF, 24'hFFFFFF);
    queue_pair(24'd0, 24'd0);
    queue_pair(TYP_D1, TYP_D2);
    wait_drained();

    // Largest coefficients, with the upper data bits dropped by the register
    write_reg(REG_SENS_BASE, 18'h3FFFF);
    write_reg(REG_OFFSET_BASE, 18'h3FFFF);
    write_reg(REG_SENS_TEMPCO, 18'h3FFFF);
    write_reg(REG_OFFSET_TEMPCO, 18'h3FFFF);
    write_reg(REG_REF_TEMP, 18'h3FFFF);
    write_reg(REG_TEMP_SLOPE, 18'h3FFFF);
    close_cfg();
    queue_pair(24'd0, 24'd0);
    queue_pair(24'hFFFFFF, 24'hFFFFFF);
    queue_pair(24'd0, 24'hFFFFFF);
    queue_pair(24'hFFFFFF, 24'd0);
    wait_drained();

    // Random phases, each under a fresh calibration; one runs without idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      randomize_cal();
      close_cfg();
      steady = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++)
        queue_random_pair();
      wait_drained();
      steady = 1'b0;
    end

    repeat (CPC_DEPTH + 4) @(posedge clk);
    if (bad_readings == 0 && reading_q.size() == 0) begin
      $display("** pressure_temperature_compensation_unit: PASSED **");
    end else begin
      $display("** pressure_temperature_compensation_unit: FAILED **");
    end
    $finish;
  end

endmodule
